// ----- rtl/bht_pkg.sv -----
// ----------------------------------------------------------------------------
// Bone hierarchy transform package
// Shared constants and types for the absolute bone matrix datapath.
// ----------------------------------------------------------------------------
package bht_pkg;

	localparam int MAX_BONES_DEF = 256;
	localparam int ID_W = 8;
	localparam int ID_SPAN = 1 << ID_W;

	typedef logic signed [31:0] elem_t;
	typedef elem_t [3:0] row_t;
	typedef row_t [3:0] mat_t;

	typedef struct packed {
		logic en;
		logic [ID_W-1:0] bone;
		logic [1:0] row;
		row_t data;
	} wr_req_t;

endpackage

// ----- rtl/bht_item_if.sv -----
// ----------------------------------------------------------------------------
// Bone hierarchy transform input channel
// Valid/ready channel carrying one local matrix row per word.
// ----------------------------------------------------------------------------
interface bht_item_if;
	logic valid;
	logic ready;
	logic [7:0] bone_id;
	logic [1:0] row_id;
	logic has_parent;
	logic [7:0] parent_id;
	logic signed [31:0] local_c0;
	logic signed [31:0] local_c1;
	logic signed [31:0] local_c2;
	logic signed [31:0] local_c3;

	modport source (
		output valid, bone_id, row_id, has_parent, parent_id,
		output local_c0, local_c1, local_c2, local_c3,
		input ready
	);

	modport sink (
		input valid, bone_id, row_id, has_parent, parent_id,
		input local_c0, local_c1, local_c2, local_c3,
		output ready
	);
endinterface

// ----- rtl/bht_result_if.sv -----
// ----------------------------------------------------------------------------
// Bone hierarchy transform result channel
// Valid/ready channel carrying one absolute matrix row per word.
// ----------------------------------------------------------------------------
interface bht_result_if;
	logic valid;
	logic ready;
	logic [7:0] out_bone_id;
	logic [1:0] out_row_id;
	logic signed [31:0] abs_c0;
	logic signed [31:0] abs_c1;
	logic signed [31:0] abs_c2;
	logic signed [31:0] abs_c3;

	modport source (
		output valid, out_bone_id, out_row_id, abs_c0, abs_c1, abs_c2, abs_c3,
		input ready
	);

	modport sink (
		input valid, out_bone_id, out_row_id, abs_c0, abs_c1, abs_c2, abs_c3,
		output ready
	);
endinterface

// ----- rtl/bht_abs_store.sv -----
// ----------------------------------------------------------------------------
// Absolute matrix store
// One whole matrix per bone, row-lane writes, registered whole-matrix read.
// ----------------------------------------------------------------------------
module bht_abs_store #(
	parameter int NUM_BONES = bht_pkg::MAX_BONES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [bht_pkg::ID_W-1:0] rd_addr,
	output bht_pkg::mat_t rd_data,
	output logic rd_valid,
	input  bht_pkg::wr_req_t wr
);
	import bht_pkg::*;

	localparam int AW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

	mat_t mem [NUM_BONES];
	logic [NUM_BONES-1:0] valid_q;
	mat_t rd_data_q;
	logic rd_valid_q;
	mat_t fill;
	logic [AW-1:0] rd_idx;
	logic [AW-1:0] wr_idx;

	assign rd_idx = rd_addr[AW-1:0];
	assign wr_idx = wr.bone[AW-1:0];

	// A bone written for the first time gets zeros in its other rows.
	always_comb begin
		fill = '0;
		fill[wr.row] = wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
		if (wr.en) begin
			if (valid_q[wr_idx]) begin
				mem[wr_idx][wr.row] <= wr.data;
			end else begin
				mem[wr_idx] <= fill;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
			if (wr.en) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_valid = rd_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> ({1'b0, wr.bone} < (ID_W + 1)'(NUM_BONES)))
		else $error("Store write beyond the bone range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr.en |-> rd_addr != wr.bone)
		else $error("Parent read collides with a write of the same bone.");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> valid_q[$past(wr_idx)])
		else $error("Written bone not marked valid.");

endmodule

// ----- rtl/bone_hierarchy_transform.sv -----
// ----------------------------------------------------------------------------
// Bone hierarchy transform
// Turns local bone matrix rows into absolute rows using the stored parent.
//
//   Channel  Role    Word
//   item     sink    bone, row, parent link and one local Q16.16 row
//   result   source  bone, row and one absolute Q16.16 row
//
// One word is accepted per cycle unless a parent hazard or a stalled result side holds
// it; it passes the stage-1, product and result registers. The parent matrix
// is read whole in one access; sixteen 32x32 multipliers fill the product stage,
// and the four-term sums and saturation fill the last. A child whose parent
// bone is still in one of the two inner stages holds the input until that bone
// has left the sum stage. Reset clears the per-bone valid bits at once.
// A stalled result lets the input keep filling the inner stages.
// ----------------------------------------------------------------------------
module bone_hierarchy_transform #(
	parameter int MAX_BONES = bht_pkg::MAX_BONES_DEF
) (
	input logic clk,
	input logic arst_n,
	bht_item_if.sink item,
	bht_result_if.source result
);
	import bht_pkg::*;

	localparam int NUM_BONES = (MAX_BONES < ID_SPAN) ? MAX_BONES : ID_SPAN;
	localparam logic [ID_W:0] BONE_LIM = (ID_W + 1)'(NUM_BONES);

	logic en1;
	logic en2;
	logic en_out;
	logic hazard;
	logic accept;
	logic p_ok;
	logic b_ok;
	row_t local_in;

	mat_t pmat;
	logic pval;
	mat_t par;
	wr_req_t wr;

	logic v1;
	logic [ID_W-1:0] bone_s1;
	logic [1:0] row_s1;
	logic child_s1;
	logic pok_s1;
	logic bok_s1;
	row_t local_s1;

	logic v2;
	logic [ID_W-1:0] bone_s2;
	logic [1:0] row_s2;
	logic child_s2;
	logic bok_s2;
	row_t local_s2;
	logic signed [63:0] prod_d [4][4];
	logic signed [63:0] prod_s2 [4][4];

	row_t res;
	logic out_v_q;
	logic [ID_W-1:0] out_bone_q;
	logic [1:0] out_row_q;
	row_t out_row_data_q;

	function automatic elem_t sat_sum(input logic signed [63:0] p0,
		input logic signed [63:0] p1, input logic signed [63:0] p2,
		input logic signed [63:0] p3);
		logic signed [65:0] sum;
		logic signed [49:0] sh;
		elem_t r;
		sum = 66'(p0) + 66'(p1) + 66'(p2) + 66'(p3);
		sh = sum[65:16];
		if (!sh[49] && (sh[48:31] != '0)) begin
			r = 32'sh7fffffff;
		end else if (sh[49] && (sh[48:31] != '1)) begin
			r = 32'sh80000000;
		end else begin
			r = sh[31:0];
		end
		return r;
	endfunction

	assign en_out = !out_v_q || result.ready;
	assign en2 = !v2 || en_out;
	assign en1 = !v1 || en2;
	assign hazard = item.has_parent &&
		((v1 && (item.parent_id == bone_s1)) || (v2 && (item.parent_id == bone_s2)));
	assign item.ready = en1 && !hazard;
	assign accept = item.valid && item.ready;
	assign p_ok = {1'b0, item.parent_id} < BONE_LIM;
	assign b_ok = {1'b0, item.bone_id} < BONE_LIM;
	assign local_in = {item.local_c3, item.local_c2, item.local_c1, item.local_c0};

	bht_abs_store #(
		.NUM_BONES(NUM_BONES)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept && item.has_parent && p_ok),
		.rd_addr(item.parent_id),
		.rd_data(pmat),
		.rd_valid(pval),
		.wr(wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) begin
				v1 <= accept;
			end
			if (en2) begin
				v2 <= v1;
			end
			if (en_out) begin
				out_v_q <= v2;
			end
		end
	end

	// Parent rows that were never written, or lie out of range, read as zeros.
	always_ff @(posedge clk) begin
		if (accept) begin
			bone_s1 <= item.bone_id;
			row_s1 <= item.row_id;
			child_s1 <= item.has_parent;
			pok_s1 <= p_ok;
			bok_s1 <= b_ok;
			local_s1 <= local_in;
		end
	end

	assign par = (child_s1 && pok_s1 && pval) ? pmat : '0;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				prod_d[c][k] = $signed(local_s1[k]) * $signed(par[k][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1) begin
			bone_s2 <= bone_s1;
			row_s2 <= row_s1;
			child_s2 <= child_s1;
			bok_s2 <= bok_s1;
			local_s2 <= local_s1;
			prod_s2 <= prod_d;
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			res[c] = child_s2 ? sat_sum(prod_s2[c][0], prod_s2[c][1], prod_s2[c][2],
				prod_s2[c][3]) : local_s2[c];
		end
	end

	always_comb begin
		wr.en = en_out && v2 && bok_s2;
		wr.bone = bone_s2;
		wr.row = row_s2;
		wr.data = res;
	end

	always_ff @(posedge clk) begin
		if (en_out && v2) begin
			out_bone_q <= bone_s2;
			out_row_q <= row_s2;
			out_row_data_q <= res;
		end
	end

	assign result.valid = out_v_q;
	assign result.out_bone_id = out_bone_q;
	assign result.out_row_id = out_row_q;
	assign result.abs_c0 = out_row_data_q[0];
	assign result.abs_c1 = out_row_data_q[1];
	assign result.abs_c2 = out_row_data_q[2];
	assign result.abs_c3 = out_row_data_q[3];

	assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.has_parent && v2 |-> item.parent_id != bone_s2)
		else $error("Child accepted while its parent row is still in flight.");

	assert property (@(posedge clk) disable iff (!arst_n)
		en_out && v2 |=> out_v_q && (result.out_bone_id == $past(bone_s2)) &&
			(result.out_row_id == $past(row_s2)))
		else $error("Result register lost a word from the sum stage.");

	assert property (@(posedge clk) disable iff (!arst_n)
		v1 && !en2 |=> v1 && $stable(bone_s1) && $stable(local_s1))
		else $error("Product stage input changed while stalled.");

endmodule

// ----- bench/tb_bone_hierarchy_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bone hierarchy transform testbench
// Streams local matrix rows through the block, predicts each absolute row
// with a bit-exact Q16.16 row-times-matrix model, and checks every result
// word against the oldest prediction while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_bone_hierarchy_transform;
	import bht_pkg::*;

	localparam int NUM_BONES = MAX_BONES_DEF;
	localparam int RUN_WORDS = 870;
	localparam int MAX_IDLE = 12;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AT_A = 400;
	localparam int HOLD_AT_B = 6000;
	localparam int DRAIN_CYCLES = 16;
	localparam elem_t ELEM_MAX = 32'sh7fffffff;
	localparam elem_t ELEM_MIN = 32'sh80000000;
	localparam elem_t ONE = 32'sh00010000;

	typedef struct packed {
		logic [7:0] bone;
		logic [1:0] row;
		logic has_parent;
		logic [7:0] parent;
		row_t data;
	} bone_word_t;

	typedef struct packed {
		logic [7:0] bone;
		logic [1:0] row;
		row_t data;
	} abs_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bht_item_if item ();
	bht_result_if result ();

	bone_hierarchy_transform #(
		.MAX_BONES(NUM_BONES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result)
	);

	always #1 clk = ~clk;

	row_t abs_matrix_mem [NUM_BONES][4];
	bone_word_t pending_words[$];
	abs_row_t expected_rows[$];
	bone_word_t in_flight;
	int errors = 0;
	int src_wait;
	int snk_wait;
	bit src_quiet;
	bit snk_quiet;
	int cycle_cnt;
	int hold_left;

	// Absolute row of one word; updates the matrix store after reading the parent.
	function automatic abs_row_t transform_row(input bone_word_t w);
		abs_row_t r;
		row_t par [4];
		logic signed [65:0] acc;
		logic signed [65:0] a;
		logic signed [65:0] b;
		logic signed [65:0] sh;
		elem_t ea;
		elem_t eb;
		r.bone = w.bone;
		r.row = w.row;
		for (int k = 0; k < 4; k++) begin
			par[k] = (int'(w.parent) < NUM_BONES) ? abs_matrix_mem[w.parent][k] : '0;
		end
		for (int c = 0; c < 4; c++) begin
			if (!w.has_parent) begin
				r.data[c] = w.data[c];
			end else begin
				acc = '0;
				for (int k = 0; k < 4; k++) begin
					ea = w.data[k];
					eb = par[k][c];
					a = ea;
					b = eb;
					acc = acc + a * b;
				end
				sh = acc >>> 16;
				if (sh > 66'sd2147483647) begin
					r.data[c] = ELEM_MAX;
				end else if (sh < -66'sd2147483648) begin
					r.data[c] = ELEM_MIN;
				end else begin
					r.data[c] = sh[31:0];
				end
			end
		end
		if (int'(w.bone) < NUM_BONES) begin
			abs_matrix_mem[w.bone][w.row] = r.data;
		end
		return r;
	endfunction

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return ELEM_MAX;
			2: return ELEM_MIN;
			3: return '0;
			4: return -32'sd1;
			default: return $urandom_range(0, 32'h80000) - 32'h40000;
		endcase
	endfunction

	task automatic add_word(input logic [7:0] b, input logic [1:0] r, input logic hp,
			input logic [7:0] p, input elem_t c0, input elem_t c1, input elem_t c2,
			input elem_t c3);
		bone_word_t w;
		w.bone = b;
		w.row = r;
		w.has_parent = hp;
		w.parent = p;
		w.data[0] = c0;
		w.data[1] = c1;
		w.data[2] = c2;
		w.data[3] = c3;
		pending_words = {pending_words, w};
	endtask

	task automatic add_bone(input logic [7:0] b, input logic hp, input logic [7:0] p);
		bit reverse;
		reverse = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < 4; i++) begin
			add_word(b, reverse ? 2'(3 - i) : 2'(i), hp, p,
				rand_elem(), rand_elem(), rand_elem(), rand_elem());
		end
	endtask

	// Input driver: one word at a time from the pending queue.
	always @(posedge clk or negedge arst_n) begin : word_driver
		bone_word_t nxt;
		if (!arst_n) begin
			item.valid <= 1'b0;
			src_wait <= 0;
			src_quiet <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				expected_rows = {expected_rows, transform_row(in_flight)};
			end
			if (!item.valid || item.ready) begin
				if (src_wait > 0) begin
					src_wait <= src_wait - 1;
					item.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					nxt = pending_words.pop_front();
					in_flight <= nxt;
					item.valid <= 1'b1;
					item.bone_id <= nxt.bone;
					item.row_id <= nxt.row;
					item.has_parent <= nxt.has_parent;
					item.parent_id <= nxt.parent;
					item.local_c0 <= nxt.data[0];
					item.local_c1 <= nxt.data[1];
					item.local_c2 <= nxt.data[2];
					item.local_c3 <= nxt.data[3];
					src_wait <= src_quiet ? 0 : $urandom_range(0, MAX_IDLE);
					if ($urandom_range(0, 39) == 0) begin
						src_quiet <= !src_quiet;
					end
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off so that the block fills up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_cnt <= 0;
			hold_left <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B) begin
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		abs_row_t got;
		abs_row_t want;
		int w;
		if (!arst_n) begin
			result.ready <= 1'b0;
			snk_wait <= 0;
			snk_quiet <= 1'b0;
		end else begin
			w = (snk_wait > 0) ? snk_wait - 1 : 0;
			if (result.valid && result.ready) begin
				got.bone = result.out_bone_id;
				got.row = result.out_row_id;
				got.data[0] = result.abs_c0;
				got.data[1] = result.abs_c1;
				got.data[2] = result.abs_c2;
				got.data[3] = result.abs_c3;
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected word, bone %0d row %0d", $time, got.bone, got.row);
					errors++;
				end else begin
					want = expected_rows.pop_front();
					if (got.bone !== want.bone) begin
						$display("%0t: out_bone_id expected %0d actual %0d", $time,
							want.bone, got.bone);
						errors++;
					end
					if (got.row !== want.row) begin
						$display("%0t: out_row_id expected %0d actual %0d", $time,
							want.row, got.row);
						errors++;
					end
					for (int c = 0; c < 4; c++) begin
						if (got.data[c] !== want.data[c]) begin
							$display("%0t: abs_c%0d of bone %0d row %0d expected %h actual %h",
								$time, c, want.bone, want.row, want.data[c], got.data[c]);
							errors++;
						end
					end
				end
				if ($urandom_range(0, 29) == 0) begin
					snk_quiet <= !snk_quiet;
				end
				w = snk_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			end
			snk_wait <= w;
			result.ready <= (w == 0) && (hold_left == 0);
		end
	end

	initial begin
		int kind;
		int depth;
		logic [7:0] b;
		logic [7:0] nb;
		logic [7:0] p;
		logic [7:0] built[$];

		arst_n = 1'b0;
		item.valid = 1'b0;
		item.bone_id = '0;
		item.row_id = '0;
		item.has_parent = 1'b0;
		item.parent_id = '0;
		item.local_c0 = '0;
		item.local_c1 = '0;
		item.local_c2 = '0;
		item.local_c3 = '0;
		result.ready = 1'b0;
		for (int i = 0; i < NUM_BONES; i++) begin
			for (int k = 0; k < 4; k++) begin
				abs_matrix_mem[i][k] = '0;
			end
		end

		// Root with identity rotation and a translation, then a child of it.
		add_word(8'd0, 2'd0, 1'b0, 8'd0, ONE, '0, '0, '0);
		add_word(8'd0, 2'd1, 1'b0, 8'd0, '0, ONE, '0, '0);
		add_word(8'd0, 2'd2, 1'b0, 8'd0, '0, '0, ONE, '0);
		add_word(8'd0, 2'd3, 1'b0, 8'd0, 32'sh00018000, -32'sh00020000, 32'sh00034000, ONE);
		add_word(8'd1, 2'd0, 1'b1, 8'd0, ELEM_MAX, ELEM_MIN, '0, -32'sd1);
		add_word(8'd1, 2'd1, 1'b1, 8'd0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
		add_word(8'd1, 2'd3, 1'b1, 8'd0, ONE, ONE, ONE, ONE);
		// A parent that was never written reads as zeros.
		add_word(8'd7, 2'd2, 1'b1, 8'd200, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		// A root ignores its parent index.
		add_word(8'd255, 2'd3, 1'b0, 8'd255, ELEM_MIN, ELEM_MAX, -32'sd1, 32'sd1);
		// Large parent rows drive both saturation limits.
		add_word(8'd2, 2'd0, 1'b0, 8'd9, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		add_word(8'd2, 2'd1, 1'b0, 8'd9, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		add_word(8'd2, 2'd2, 1'b0, 8'd9, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		add_word(8'd2, 2'd3, 1'b0, 8'd9, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		add_word(8'd3, 2'd0, 1'b1, 8'd2, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
		add_word(8'd3, 2'd1, 1'b1, 8'd2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
		// A bone that is its own parent reads the old rows, back to back.
		add_word(8'd0, 2'd2, 1'b1, 8'd0, ONE, ONE, 32'sh00020000, -32'sh00010000);
		add_word(8'd0, 2'd2, 1'b1, 8'd0, ONE, '0, ONE, ONE);
		add_word(8'd254, 2'd1, 1'b1, 8'd255, 32'sh00020000, ONE, '0, ONE);
		add_word(8'd255, 2'd0, 1'b1, 8'd255, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN);
		add_word(8'd4, 2'd0, 1'b1, 8'd1, ELEM_MAX, 32'sd1, -32'sd1, ELEM_MIN);
		built = {built, 8'd0};
		built = {built, 8'd1};
		built = {built, 8'd2};

		while (pending_words.size() < RUN_WORDS) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				b = 8'($urandom);
				add_bone(b, 1'b0, 8'($urandom));
				built = {built, b};
				depth = $urandom_range(1, 4);
				for (int d = 0; d < depth; d++) begin
					nb = 8'($urandom);
					add_bone(nb, 1'b1, b);
					built = {built, nb};
					b = nb;
				end
			end else if (kind < 8) begin
				p = built[$urandom_range(0, built.size() - 1)];
				b = ($urandom_range(0, 2) == 0) ? p : 8'($urandom);
				add_word(b, 2'($urandom), 1'b1, p, rand_elem(), rand_elem(), rand_elem(),
					rand_elem());
			end else begin
				add_word(8'($urandom), 2'($urandom), 1'($urandom), 8'($urandom),
					$urandom, $urandom, $urandom, $urandom);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || item.valid) @(posedge clk);
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("tb_bone_hierarchy_transform: PASS");
		end else begin
			$display("tb_bone_hierarchy_transform: FAIL");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb_bone_hierarchy_transform: FAIL");
		$finish;
	end

endmodule
